FILE: design/ihcv_pkg.sv
`timescale 1ns / 1ps

package ihcv_pkg;

    // Field widths fixed by the interface.
    localparam int ADDR_W  = 24;
    localparam int SLOT_W  = 25;
    localparam int WORD_W  = 32;
    // Covered byte count never exceeds an accepted size, which is at most 2^25 - 1.
    localparam int COUNT_W = 25;

    // Operation codes carried by an input beat.
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_APP_START   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_SIZE   = 2'd2;

    // Configuration reset values.
    localparam logic [ADDR_W-1:0] HEADER_BASE_RST = 24'd8192;
    localparam logic [ADDR_W-1:0] APP_START_RST   = 24'd8192;
    localparam logic [SLOT_W-1:0] SLOT_SIZE_RST   = 25'd65536;

    // CRC constants.
    localparam logic [31:0] CRC32_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC32_ONES = 32'hFFFF_FFFF;
    localparam logic [7:0]  CRC8_INIT  = 8'hFF;
    localparam logic [7:0]  CRC8_POLY  = 8'h07;

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] byte_address;
        logic [7:0]        data_byte;
    } t_in_item;

    typedef struct packed {
        logic        image_valid;
        logic        header_ready;
        logic [31:0] crc32_actual;
        logic [31:0] crc32_expected;
        logic [7:0]  crc8_actual;
    } t_out_item;

    // Header state after the current step, as seen by the coverage logic.
    typedef struct packed {
        logic              full;
        logic              start_ok;
        logic              size_ok;
        logic [WORD_W-1:0] size;
        logic [WORD_W-1:0] crc;
    } t_hdr_info;

    // Coverage state after the current step.
    typedef struct packed {
        logic        valid;
        logic [31:0] crc32;
        logic [7:0]  crc8;
    } t_cov_info;

    // Reflected CRC32, one byte.
    function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ CRC32_POLY) : (v >> 1);
        end
        return v;
    endfunction

    // MSB-first CRC-8, one byte.
    function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] v;
        v = c ^ b;
        for (int k = 0; k < 8; k++) begin
            v = v[7] ? ((v << 1) ^ CRC8_POLY) : (v << 1);
        end
        return v;
    endfunction

endpackage

FILE: design/image_header_crc_verifier_core.sv
`timescale 1ns / 1ps

// A beat accepted into the input register is stepped into the result register when
// that register is empty or its result is taken; a held result stalls the step.
// Throughput: one byte per cycle while no result is held; the byte-wide CRC32/CRC-8
// update and header parse form the state loop from input register to result register.
// Reset (i_rst_n low, synchronous) clears all verification state and returns the
// configuration registers to their defaults; there is no clearing pass.
module image_header_crc_verifier_core #(
    parameter int HEADER_BYTES       = 16,
    parameter int SIZE_FIELD_OFFSET  = 0,
    parameter int CRC_FIELD_OFFSET   = 4,
    parameter int START_FIELD_OFFSET = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  ihcv_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output ihcv_pkg::t_out_item            o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ihcv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ihcv_pkg::SLOT_W-1:0]    i_cfg_data
);
    import ihcv_pkg::*;

    logic [ADDR_W-1:0] r_header_base;
    logic [ADDR_W-1:0] r_app_start;
    logic [SLOT_W-1:0] r_slot_size;

    logic      s1_valid;
    t_in_item  s1_item;
    logic      advance;
    logic      step;
    t_hdr_info hdr;
    t_cov_info cov;

    logic      r_out_valid;
    t_out_item r_out_data;

    // Configuration beats are always taken and land at once, so they belong
    // between bursts of traffic.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_base <= HEADER_BASE_RST;
            r_app_start   <= APP_START_RST;
            r_slot_size   <= SLOT_SIZE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HEADER_BASE: r_header_base <= i_cfg_data[ADDR_W-1:0];
                CFG_APP_START:   r_app_start   <= i_cfg_data[ADDR_W-1:0];
                CFG_SLOT_SIZE:   r_slot_size   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The held beat steps the state when the result register can take it.
    assign advance = !r_out_valid || i_out_ready;
    assign step    = s1_valid && advance;

    ihcv_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_data    (i_in_data),
        .i_advance (advance),
        .o_valid   (s1_valid),
        .o_data    (s1_item)
    );

    ihcv_hdr #(
        .HEADER_BYTES       (HEADER_BYTES),
        .SIZE_FIELD_OFFSET  (SIZE_FIELD_OFFSET),
        .CRC_FIELD_OFFSET   (CRC_FIELD_OFFSET),
        .START_FIELD_OFFSET (START_FIELD_OFFSET)
    ) u_hdr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_item        (s1_item),
        .i_header_base (r_header_base),
        .i_app_start   (r_app_start),
        .i_slot_size   (r_slot_size),
        .o_hdr         (hdr)
    );

    ihcv_cov u_cov (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (s1_item),
        .i_hdr       (hdr),
        .i_app_start (r_app_start),
        .o_cov       (cov)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data.image_valid    <= cov.valid;
            r_out_data.header_ready   <= hdr.full;
            r_out_data.crc32_actual   <= cov.crc32;
            r_out_data.crc32_expected <= hdr.crc;
            r_out_data.crc8_actual    <= cov.crc8;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Every stepped beat produces exactly one result beat.
    a_step_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("stepped beat produced no result");

    // An image only reads valid with its header in place.
    a_valid_has_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.image_valid) |-> r_out_data.header_ready)
        else $error("image valid without header");

endmodule

FILE: design/ihcv_in_reg.sv
`timescale 1ns / 1ps

module ihcv_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ihcv_pkg::t_in_item i_data,
    input  logic              i_advance,
    output logic              o_valid,
    output ihcv_pkg::t_in_item o_data
);
    import ihcv_pkg::*;

    logic     r_valid;
    t_in_item r_data;

    // The stage takes a new beat when empty or when its beat moves on.
    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

    // A held beat is never dropped while the result side is stalled.
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_advance) |=> (r_valid && $stable(r_data)))
        else $error("input stage lost a stalled beat");

    // A beat taken while the stage was empty is present next cycle.
    a_take_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !r_valid) |=> r_valid)
        else $error("input stage missed a beat");

endmodule

FILE: design/ihcv_hdr.sv
`timescale 1ns / 1ps

module ihcv_hdr #(
    parameter int HEADER_BYTES       = 16,
    parameter int SIZE_FIELD_OFFSET  = 0,
    parameter int CRC_FIELD_OFFSET   = 4,
    parameter int START_FIELD_OFFSET = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  ihcv_pkg::t_in_item            i_item,
    input  logic [ihcv_pkg::ADDR_W-1:0]   i_header_base,
    input  logic [ihcv_pkg::ADDR_W-1:0]   i_app_start,
    input  logic [ihcv_pkg::SLOT_W-1:0]   i_slot_size,
    output ihcv_pkg::t_hdr_info           o_hdr
);
    import ihcv_pkg::*;

    localparam int CW = $clog2(HEADER_BYTES + 1);
    localparam int IW = $clog2(HEADER_BYTES);

    logic [7:0]        r_store [HEADER_BYTES];
    logic [CW-1:0]     r_count;
    logic [WORD_W-1:0] r_size;
    logic [WORD_W-1:0] r_crc;
    logic              r_start_ok;
    logic              r_size_ok;

    logic [CW-1:0]     n_count;
    logic [WORD_W-1:0] n_size;
    logic [WORD_W-1:0] n_crc;
    logic              n_start_ok;
    logic              n_size_ok;

    logic              restart;
    logic              in_window;
    logic              capture;
    logic              completing;
    logic [ADDR_W-1:0] window_off;
    logic [7:0]        view [HEADER_BYTES];
    logic [WORD_W-1:0] size_word;
    logic [WORD_W-1:0] crc_word;
    logic [WORD_W-1:0] start_word;
    logic              p_start_ok;
    logic              p_size_ok;

    assign restart    = (i_item.operation == OP_RESTART);
    assign window_off = i_item.byte_address - i_header_base;
    assign in_window  = (i_item.byte_address >= i_header_base) &&
                        (window_off < ADDR_W'(HEADER_BYTES));
    assign capture    = !restart && in_window && (r_count < CW'(HEADER_BYTES));
    assign completing = capture && (r_count == CW'(HEADER_BYTES - 1));

    // Header as it stands once this beat's byte takes the last slot.
    always_comb begin
        for (int p = 0; p < HEADER_BYTES; p++) begin
            view[p] = (p == HEADER_BYTES - 1) ? i_item.data_byte : r_store[p];
        end
    end

    // Little-endian field words; positions past the header read as zero.
    for (genvar k = 0; k < 4; k++) begin : g_fields
        if (SIZE_FIELD_OFFSET + k < HEADER_BYTES) begin : g_size
            assign size_word[8*k +: 8] = view[SIZE_FIELD_OFFSET + k];
        end else begin : g_size_zero
            assign size_word[8*k +: 8] = 8'd0;
        end
        if (CRC_FIELD_OFFSET + k < HEADER_BYTES) begin : g_crc
            assign crc_word[8*k +: 8] = view[CRC_FIELD_OFFSET + k];
        end else begin : g_crc_zero
            assign crc_word[8*k +: 8] = 8'd0;
        end
        if (START_FIELD_OFFSET + k < HEADER_BYTES) begin : g_start
            assign start_word[8*k +: 8] = view[START_FIELD_OFFSET + k];
        end else begin : g_start_zero
            assign start_word[8*k +: 8] = 8'd0;
        end
    end

    assign p_start_ok = (start_word == {{(WORD_W - ADDR_W){1'b0}}, i_app_start});
    assign p_size_ok  = (size_word != '0) &&
                        (size_word <= {{(WORD_W - SLOT_W){1'b0}}, i_slot_size});

    // Header state after this step.
    always_comb begin
        n_count    = r_count;
        n_size     = r_size;
        n_crc      = r_crc;
        n_start_ok = r_start_ok;
        n_size_ok  = r_size_ok;
        if (restart) begin
            n_count    = '0;
            n_size     = '0;
            n_crc      = '0;
            n_start_ok = 1'b1;
            n_size_ok  = 1'b0;
        end else if (capture) begin
            n_count = r_count + CW'(1);
            if (completing) begin
                n_size     = size_word;
                n_crc      = crc_word;
                n_start_ok = p_start_ok;
                n_size_ok  = p_size_ok;
            end
        end
    end

    assign o_hdr.full     = (n_count == CW'(HEADER_BYTES));
    assign o_hdr.start_ok = n_start_ok;
    assign o_hdr.size_ok  = n_size_ok;
    assign o_hdr.size     = n_size;
    assign o_hdr.crc      = n_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_size     <= '0;
            r_crc      <= '0;
            r_start_ok <= 1'b1;
            r_size_ok  <= 1'b0;
        end else if (i_step) begin
            r_count    <= n_count;
            r_size     <= n_size;
            r_crc      <= n_crc;
            r_start_ok <= n_start_ok;
            r_size_ok  <= n_size_ok;
        end
    end

    // Header bytes are stored in arrival order.
    always_ff @(posedge i_clk) begin
        if (i_step && capture) begin
            r_store[r_count[IW-1:0]] <= i_item.data_byte;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(HEADER_BYTES))
        else $error("header count past header length");

    // A full header stays full until a restart.
    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !restart && r_count == CW'(HEADER_BYTES)) |=>
        (r_count == CW'(HEADER_BYTES)))
        else $error("full header lost without restart");

    // Before the header is full the parsed fields keep their cleared values.
    a_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != CW'(HEADER_BYTES)) |-> (r_crc == '0 && !r_size_ok))
        else $error("header fields set before header full");

endmodule

FILE: design/ihcv_cov.sv
`timescale 1ns / 1ps

module ihcv_cov (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  ihcv_pkg::t_in_item          i_item,
    input  ihcv_pkg::t_hdr_info         i_hdr,
    input  logic [ihcv_pkg::ADDR_W-1:0] i_app_start,
    output ihcv_pkg::t_cov_info         o_cov
);
    import ihcv_pkg::*;

    logic [31:0]        r_crc32;
    logic [7:0]         r_crc8;
    logic [COUNT_W-1:0] r_covered;
    logic               r_valid;

    logic [31:0]        n_crc32;
    logic [7:0]         n_crc8;
    logic [COUNT_W-1:0] n_covered;
    logic               n_valid;

    logic               restart;
    logic               take_byte;
    logic [31:0]        crc32_upd;
    logic [COUNT_W-1:0] covered_inc;

    assign restart     = (i_item.operation == OP_RESTART);
    assign crc32_upd   = crc32_byte(r_crc32, i_item.data_byte);
    assign covered_inc = r_covered + COUNT_W'(1);

    // Bytes from app start on are covered after a good header, until size is met.
    assign take_byte = !restart && i_hdr.full && i_hdr.start_ok && i_hdr.size_ok &&
                       (i_item.byte_address >= i_app_start) &&
                       ({{(WORD_W - COUNT_W){1'b0}}, r_covered} < i_hdr.size);

    always_comb begin
        n_crc32   = r_crc32;
        n_crc8    = r_crc8;
        n_covered = r_covered;
        n_valid   = r_valid;
        if (restart) begin
            n_crc32   = CRC32_ONES;
            n_crc8    = CRC8_INIT;
            n_covered = '0;
            n_valid   = 1'b0;
        end else if (take_byte) begin
            n_crc32   = crc32_upd;
            n_crc8    = crc8_byte(r_crc8, i_item.data_byte);
            n_covered = covered_inc;
            n_valid   = ({{(WORD_W - COUNT_W){1'b0}}, covered_inc} == i_hdr.size) &&
                        ((crc32_upd ^ CRC32_ONES) == i_hdr.crc);
        end
    end

    assign o_cov.valid = n_valid;
    assign o_cov.crc32 = n_crc32 ^ CRC32_ONES;
    assign o_cov.crc8  = n_crc8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc32   <= CRC32_ONES;
            r_crc8    <= CRC8_INIT;
            r_covered <= '0;
            r_valid   <= 1'b0;
        end else if (i_step) begin
            r_crc32   <= n_crc32;
            r_crc8    <= n_crc8;
            r_covered <= n_covered;
            r_valid   <= n_valid;
        end
    end

    // A valid image has had at least one byte covered.
    a_valid_needs_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_covered != '0))
        else $error("image valid with nothing covered");

    // A restart returns both CRCs and the flag to their initial values.
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && restart) |=>
        (r_crc8 == CRC8_INIT && r_crc32 == CRC32_ONES && !r_valid && r_covered == '0))
        else $error("restart did not clear coverage state");

endmodule
